FILE: sv/qstp_pkg.sv
`default_nettype none

package qstp_pkg;

  localparam int COORD_W     = 32;
  localparam int QUAT_W      = 16;
  localparam int SCALE_W     = 16;
  localparam int NUM_AXES    = 3;
  localparam int QUAT_FRAC   = 28;
  localparam int SCALE_FRAC  = 12;
  localparam int MAT_FRAC    = 52 - COORD_W;
  localparam int ENTRY_SHIFT = 40 - MAT_FRAC;
  localparam int QPROD_W     = 2 * QUAT_W;
  localparam int Q_W         = QPROD_W + 2;
  localparam int RAW_W       = Q_W + SCALE_W;
  localparam int ENTRY_W     = RAW_W - ENTRY_SHIFT;
  localparam int PROD_W      = ENTRY_W + COORD_W;
  localparam int ACC_W       = PROD_W + 2;

  localparam int PT_STAGES   = 4;
  localparam int S_PROD      = PT_STAGES;
  localparam int S_ACC       = PT_STAGES + 1;
  localparam int S_OUT       = PT_STAGES + 2;
  localparam int STAGES      = PT_STAGES + 3;

  localparam int CFG_ADDR_W  = 6;
  localparam int CFG_DATA_W  = 64;
  localparam int REG_IDX_W   = 3;
  localparam int REG_LSB     = 3;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef coord_t [NUM_AXES-1:0]      vec_t;
  typedef logic signed [QUAT_W-1:0]   quat_t;
  typedef logic signed [SCALE_W-1:0]  scale_t;
  typedef logic signed [QPROD_W-1:0]  qprod_t;
  typedef logic signed [Q_W-1:0]      q_t;
  typedef logic signed [RAW_W-1:0]    raw_t;
  typedef logic signed [ENTRY_W-1:0]  entry_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef entry_t [NUM_AXES-1:0][NUM_AXES-1:0] mat_t;
  typedef logic [REG_IDX_W-1:0]       reg_idx_t;

  typedef struct packed {
    quat_t                     qx;
    quat_t                     qy;
    quat_t                     qz;
    quat_t                     qw;
    scale_t [NUM_AXES-1:0]     scale;
    vec_t                      offset;
  } qstp_cfg_t;

  localparam reg_idx_t REG_QUAT_X   = 3'd0;
  localparam reg_idx_t REG_QUAT_Y   = 3'd1;
  localparam reg_idx_t REG_QUAT_Z   = 3'd2;
  localparam reg_idx_t REG_QUAT_W   = 3'd3;
  localparam reg_idx_t REG_SCALE    = 3'd4;
  localparam reg_idx_t REG_OFFSET_X = 3'd5;
  localparam reg_idx_t REG_OFFSET_Y = 3'd6;
  localparam reg_idx_t REG_OFFSET_Z = 3'd7;

  localparam quat_t  QUAT_UNIT  = quat_t'(1) <<< (QUAT_W - 2);
  localparam scale_t SCALE_ONE  = scale_t'(1) <<< SCALE_FRAC;
  localparam q_t     QUAT_ONE   = q_t'(1) <<< QUAT_FRAC;
  localparam raw_t   ENTRY_HALF = raw_t'(1) <<< (ENTRY_SHIFT - 1);
  localparam acc_t   ACC_HALF   = acc_t'(1) <<< (MAT_FRAC - 1);
  localparam acc_t   COORD_HI   = (acc_t'(1) <<< (COORD_W - 1)) - acc_t'(1);
  localparam acc_t   COORD_LO   = -COORD_HI - acc_t'(1);

  localparam qstp_cfg_t CFG_RESET = '{
    qx:     '0,
    qy:     '0,
    qz:     '0,
    qw:     QUAT_UNIT,
    scale:  {SCALE_ONE, SCALE_ONE, SCALE_ONE},
    offset: '0
  };

endpackage

`default_nettype wire

FILE: sv/qstp_if.sv
`default_nettype none

interface qstp_in_if;
  logic            valid;
  logic            ready;
  qstp_pkg::coord_t point_x;
  qstp_pkg::coord_t point_y;
  qstp_pkg::coord_t point_z;

  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface qstp_out_if;
  logic            valid;
  logic            ready;
  qstp_pkg::coord_t world_x;
  qstp_pkg::coord_t world_y;
  qstp_pkg::coord_t world_z;

  modport source (output valid, output world_x, output world_y, output world_z, input ready);
  modport sink   (input valid, input world_x, input world_y, input world_z, output ready);
endinterface

`default_nettype wire

FILE: sv/qstp_cfg_regs.sv
`default_nettype none

module qstp_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [qstp_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [qstp_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [qstp_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output qstp_pkg::qstp_cfg_t                 cfg
);

  localparam int QPAD = qstp_pkg::CFG_DATA_W - qstp_pkg::QUAT_W;
  localparam int SPAD = qstp_pkg::CFG_DATA_W - qstp_pkg::NUM_AXES * qstp_pkg::SCALE_W;
  localparam int CPAD = qstp_pkg::CFG_DATA_W - qstp_pkg::COORD_W;

  qstp_pkg::qstp_cfg_t cfg_r;
  qstp_pkg::qstp_cfg_t cfg_nxt;
  qstp_pkg::reg_idx_t  idx;
  logic                wr;

  assign idx    = paddr[qstp_pkg::REG_LSB +: qstp_pkg::REG_IDX_W];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        qstp_pkg::REG_QUAT_X:   cfg_nxt.qx = pwdata[qstp_pkg::QUAT_W-1:0];
        qstp_pkg::REG_QUAT_Y:   cfg_nxt.qy = pwdata[qstp_pkg::QUAT_W-1:0];
        qstp_pkg::REG_QUAT_Z:   cfg_nxt.qz = pwdata[qstp_pkg::QUAT_W-1:0];
        qstp_pkg::REG_QUAT_W:   cfg_nxt.qw = pwdata[qstp_pkg::QUAT_W-1:0];
        qstp_pkg::REG_SCALE:
          cfg_nxt.scale = pwdata[qstp_pkg::NUM_AXES*qstp_pkg::SCALE_W-1:0];
        qstp_pkg::REG_OFFSET_X: cfg_nxt.offset[0] = pwdata[qstp_pkg::COORD_W-1:0];
        qstp_pkg::REG_OFFSET_Y: cfg_nxt.offset[1] = pwdata[qstp_pkg::COORD_W-1:0];
        qstp_pkg::REG_OFFSET_Z: cfg_nxt.offset[2] = pwdata[qstp_pkg::COORD_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      qstp_pkg::REG_QUAT_X:   prdata = {{QPAD{1'b0}}, cfg_r.qx};
      qstp_pkg::REG_QUAT_Y:   prdata = {{QPAD{1'b0}}, cfg_r.qy};
      qstp_pkg::REG_QUAT_Z:   prdata = {{QPAD{1'b0}}, cfg_r.qz};
      qstp_pkg::REG_QUAT_W:   prdata = {{QPAD{1'b0}}, cfg_r.qw};
      qstp_pkg::REG_SCALE:    prdata = {{SPAD{1'b0}}, cfg_r.scale};
      qstp_pkg::REG_OFFSET_X: prdata = {{CPAD{1'b0}}, cfg_r.offset[0]};
      qstp_pkg::REG_OFFSET_Y: prdata = {{CPAD{1'b0}}, cfg_r.offset[1]};
      qstp_pkg::REG_OFFSET_Z: prdata = {{CPAD{1'b0}}, cfg_r.offset[2]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= qstp_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/qstp_matrix.sv
`default_nettype none

module qstp_matrix (
  input  logic                clk,
  input  qstp_pkg::qstp_cfg_t cfg,
  output qstp_pkg::mat_t      mat
);

  function automatic qstp_pkg::q_t dbl_prod(qstp_pkg::quat_t a, qstp_pkg::quat_t b);
    qstp_pkg::qprod_t p;
    p = a * b;
    return qstp_pkg::q_t'(p) <<< 1;
  endfunction

  qstp_pkg::q_t xx_r, yy_r, zz_r, yz_r, wx_r, xy_r, wz_r, xz_r, wy_r;
  qstp_pkg::scale_t [qstp_pkg::NUM_AXES-1:0] scale_r;
  qstp_pkg::q_t     c     [qstp_pkg::NUM_AXES][qstp_pkg::NUM_AXES];
  qstp_pkg::raw_t   raw_nxt [qstp_pkg::NUM_AXES][qstp_pkg::NUM_AXES];
  qstp_pkg::raw_t   raw_r   [qstp_pkg::NUM_AXES][qstp_pkg::NUM_AXES];
  qstp_pkg::mat_t   entry_nxt;
  qstp_pkg::mat_t   entry_r;

  // The matrix follows the registers continuously through its product, raw and entry registers.
  always_ff @(posedge clk) begin
    xx_r    <= dbl_prod(cfg.qx, cfg.qx);
    yy_r    <= dbl_prod(cfg.qy, cfg.qy);
    zz_r    <= dbl_prod(cfg.qz, cfg.qz);
    yz_r    <= dbl_prod(cfg.qy, cfg.qz);
    wx_r    <= dbl_prod(cfg.qw, cfg.qx);
    xy_r    <= dbl_prod(cfg.qx, cfg.qy);
    wz_r    <= dbl_prod(cfg.qw, cfg.qz);
    xz_r    <= dbl_prod(cfg.qx, cfg.qz);
    wy_r    <= dbl_prod(cfg.qw, cfg.qy);
    scale_r <= cfg.scale;
    raw_r   <= raw_nxt;
    entry_r <= entry_nxt;
  end

  always_comb begin
    c[0][0] = qstp_pkg::QUAT_ONE - (yy_r + zz_r);
    c[0][1] = xy_r - wz_r;
    c[0][2] = xz_r + wy_r;
    c[1][0] = xy_r + wz_r;
    c[1][1] = qstp_pkg::QUAT_ONE - (xx_r + zz_r);
    c[1][2] = yz_r - wx_r;
    c[2][0] = xz_r - wy_r;
    c[2][1] = yz_r + wx_r;
    c[2][2] = qstp_pkg::QUAT_ONE - (xx_r + yy_r);
    for (int i = 0; i < qstp_pkg::NUM_AXES; i++) begin
      for (int j = 0; j < qstp_pkg::NUM_AXES; j++) begin
        raw_nxt[i][j] = qstp_pkg::raw_t'(c[i][j]) *
                        qstp_pkg::raw_t'($signed(scale_r[j]));
      end
    end
  end

  always_comb begin
    qstp_pkg::raw_t rnd;
    rnd = '0;
    for (int i = 0; i < qstp_pkg::NUM_AXES; i++) begin
      for (int j = 0; j < qstp_pkg::NUM_AXES; j++) begin
        rnd = (raw_r[i][j] + qstp_pkg::ENTRY_HALF) >>> qstp_pkg::ENTRY_SHIFT;
        entry_nxt[i][j] = rnd[qstp_pkg::ENTRY_W-1:0];
      end
    end
  end

  assign mat = entry_r;

endmodule

`default_nettype wire

FILE: sv/qstp_pipe.sv
`default_nettype none

module qstp_pipe (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  qstp_pkg::vec_t  in_point,
  output logic            out_valid,
  input  logic            out_ready,
  output qstp_pkg::vec_t  out_world,
  input  qstp_pkg::mat_t  mat,
  input  qstp_pkg::vec_t  offset
);

  logic [qstp_pkg::STAGES-1:0] v_r;
  logic [qstp_pkg::STAGES-1:0] v_nxt;
  logic [qstp_pkg::STAGES-1:0] en;

  qstp_pkg::vec_t  pt_r     [qstp_pkg::PT_STAGES];
  qstp_pkg::prod_t prod_nxt [qstp_pkg::NUM_AXES][qstp_pkg::NUM_AXES];
  qstp_pkg::prod_t prod_r   [qstp_pkg::NUM_AXES][qstp_pkg::NUM_AXES];
  qstp_pkg::acc_t  acc_nxt  [qstp_pkg::NUM_AXES];
  qstp_pkg::acc_t  acc_r    [qstp_pkg::NUM_AXES];
  qstp_pkg::vec_t  world_nxt;
  qstp_pkg::vec_t  world_r;

  // A stage takes a new request when it is empty or its own contents move on.
  always_comb begin
    en[qstp_pkg::STAGES-1] = !v_r[qstp_pkg::STAGES-1] || out_ready;
    for (int k = qstp_pkg::STAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int k = 1; k < qstp_pkg::STAGES; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  assign in_ready  = rst_n && en[0];
  assign out_valid = v_r[qstp_pkg::S_OUT];
  assign out_world = world_r;

  always_comb begin
    for (int i = 0; i < qstp_pkg::NUM_AXES; i++) begin
      for (int j = 0; j < qstp_pkg::NUM_AXES; j++) begin
        prod_nxt[i][j] = qstp_pkg::prod_t'($signed(mat[i][j])) *
                         qstp_pkg::prod_t'($signed(pt_r[qstp_pkg::PT_STAGES-1][j]));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < qstp_pkg::NUM_AXES; i++) begin
      acc_nxt[i] = qstp_pkg::acc_t'(prod_r[i][0]) + qstp_pkg::acc_t'(prod_r[i][1]) +
                   qstp_pkg::acc_t'(prod_r[i][2]) +
                   (qstp_pkg::acc_t'($signed(offset[i])) <<< qstp_pkg::MAT_FRAC) +
                   qstp_pkg::ACC_HALF;
    end
  end

  always_comb begin
    qstp_pkg::acc_t sh;
    sh = '0;
    for (int i = 0; i < qstp_pkg::NUM_AXES; i++) begin
      sh = acc_r[i] >>> qstp_pkg::MAT_FRAC;
      priority if (sh > qstp_pkg::COORD_HI) begin
        world_nxt[i] = qstp_pkg::COORD_HI[qstp_pkg::COORD_W-1:0];
      end else if (sh < qstp_pkg::COORD_LO) begin
        world_nxt[i] = qstp_pkg::COORD_LO[qstp_pkg::COORD_W-1:0];
      end else begin
        world_nxt[i] = sh[qstp_pkg::COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pt_r[0] <= in_point;
    end
    for (int k = 1; k < qstp_pkg::PT_STAGES; k++) begin
      if (en[k]) begin
        pt_r[k] <= pt_r[k-1];
      end
    end
    if (en[qstp_pkg::S_PROD]) begin
      prod_r <= prod_nxt;
    end
    if (en[qstp_pkg::S_ACC]) begin
      acc_r <= acc_nxt;
    end
    if (en[qstp_pkg::S_OUT]) begin
      world_r <= world_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/quat_scale_translate_point_core.sv
// Point transform: world = R(q) * S * point + offset, all coordinates signed Q16.16.
// Points arrive on in_ch as valid/ready requests and results leave on out_ch in the
// same order, one result for each point. The transform is held in eight registers
// behind the APB-style cfg_ port; a write completes in its access cycle and reads
// return the stored value. Registers are only to be written while no point is in
// flight.
// The matrix is rebuilt from the registers by a three-stage setup pipeline, so
// each point spends four stages in an alignment line before its products are
// formed, then one stage each for the products, the sum and the saturation.
// A request passes the four alignment registers, the product register and the
// sum register before the result register is loaded, and one point is accepted
// in every cycle while the receiver takes results.
// When the receiver stalls, requests move up into empty stages and the input
// stops only once all seven stages hold a request; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties the pipeline, holds in_ch.ready low and
// returns the registers to the identity transform with unit scale.

`default_nettype none

module quat_scale_translate_point_core (
  input  logic                               clk,
  input  logic                               rst_n,
  qstp_in_if.sink                            in_ch,
  qstp_out_if.source                         out_ch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [qstp_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [qstp_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [qstp_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  qstp_pkg::qstp_cfg_t cfg;
  qstp_pkg::mat_t      mat;
  qstp_pkg::vec_t      in_point;
  qstp_pkg::vec_t      out_world;
  logic                in_ready;
  logic                out_valid;

  assign in_point[0] = in_ch.point_x;
  assign in_point[1] = in_ch.point_y;
  assign in_point[2] = in_ch.point_z;
  assign in_ch.ready = in_ready;

  assign out_ch.valid   = out_valid;
  assign out_ch.world_x = out_world[0];
  assign out_ch.world_y = out_world[1];
  assign out_ch.world_z = out_world[2];

  qstp_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  qstp_matrix u_matrix (
    .clk (clk),
    .cfg (cfg),
    .mat (mat)
  );

  qstp_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .in_point  (in_point),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_world (out_world),
    .mat       (mat),
    .offset    (cfg.offset)
  );

endmodule

`default_nettype wire

FILE: sv/qstp_checker.sv
`default_nettype none

module qstp_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input qstp_pkg::coord_t world_x,
  input qstp_pkg::coord_t world_y,
  input qstp_pkg::coord_t world_z
);

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while the receiver takes results");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready
      ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing seven cycles after an unstalled request");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(world_x) && $stable(world_y) &&
      $stable(world_z))
    else $error("stalled result changed");

endmodule

bind quat_scale_translate_point_core qstp_checker u_qstp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .world_x   (out_ch.world_x),
  .world_y   (out_ch.world_y),
  .world_z   (out_ch.world_z)
);

`default_nettype wire
